/* rtl/hrkm_pkg.sv */
// Package with the shared types, constants and usage translation for the key-matrix translator.
`timescale 1ns / 1ps

package hrkm_pkg;

  localparam logic [7:0] SHIFT_BITS   = 8'h22;
  localparam logic [7:0] CONTROL_BITS = 8'h11;
  localparam logic [7:0] USAGE_STAR   = 8'h25;
  localparam logic [7:0] USAGE_COLON  = 8'h33;
  localparam logic [7:0] USAGE_PAUSE  = 8'h45;
  localparam logic [7:0] USAGE_SCROLL = 8'h48;
  localparam logic [7:0] USAGE_DELETE = 8'h4c;
  localparam logic [7:0] CODE_SHIFTED = 8'h48;
  localparam logic [3:0] MAX_EVENTS   = 4'd14;

  typedef enum logic [1:0] {
    EV_KEY     = 2'd0,
    EV_BREAK   = 2'd1,
    EV_CHOOSER = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic       valid;
    ev_kind_t   kind;
    logic [2:0] row;
    logic [3:0] col;
    logic       pressed;
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_SHIFT,
    ST_CTRL,
    ST_PRESS,
    ST_FLUSH
  } st_t;

  // Row in the high nibble, column in the low nibble; zero means unmapped.
  function automatic logic [7:0] usage_code(input logic [7:0] u);
    logic [7:0] c;
    unique case (u)
      8'h04: c = 8'h41;  8'h05: c = 8'h64;  8'h06: c = 8'h52;  8'h07: c = 8'h32;
      8'h08: c = 8'h22;  8'h09: c = 8'h43;  8'h0a: c = 8'h53;  8'h0b: c = 8'h54;
      8'h0c: c = 8'h25;  8'h0d: c = 8'h45;  8'h0e: c = 8'h46;  8'h0f: c = 8'h56;
      8'h10: c = 8'h65;  8'h11: c = 8'h55;  8'h12: c = 8'h36;  8'h13: c = 8'h37;
      8'h14: c = 8'h10;  8'h15: c = 8'h33;  8'h16: c = 8'h51;  8'h17: c = 8'h23;
      8'h18: c = 8'h35;  8'h19: c = 8'h63;  8'h1a: c = 8'h21;  8'h1b: c = 8'h42;
      8'h1c: c = 8'h44;  8'h1d: c = 8'h61;
      8'h1e: c = 8'h30;  8'h1f: c = 8'h31;  8'h20: c = 8'h11;  8'h21: c = 8'h12;
      8'h22: c = 8'h13;  8'h23: c = 8'h34;  8'h24: c = 8'h24;  8'h25: c = 8'h15;
      8'h26: c = 8'h26;  8'h27: c = 8'h27;
      8'h28: c = 8'h49;  8'h29: c = 8'h70;  8'h2a: c = 8'h59;  8'h2b: c = 8'h60;
      8'h2c: c = 8'h62;  8'h2d: c = 8'h57;  8'h2e: c = 8'h17;  8'h2f: c = 8'h38;
      8'h30: c = 8'h58;  8'h31: c = 8'h78;  8'h33: c = 8'h47;  8'h34: c = 8'h48;
      8'h35: c = 8'h28;  8'h36: c = 8'h66;  8'h37: c = 8'h67;  8'h38: c = 8'h68;
      8'h39: c = 8'h40;
      8'h3a: c = 8'h71;  8'h3b: c = 8'h72;  8'h3c: c = 8'h73;  8'h3d: c = 8'h14;
      8'h3e: c = 8'h74;  8'h3f: c = 8'h75;  8'h40: c = 8'h16;  8'h41: c = 8'h76;
      8'h42: c = 8'h77;  8'h43: c = 8'h20;
      8'h49: c = 8'h69;  8'h4c: c = 8'h59;  8'h4f: c = 8'h79;  8'h50: c = 8'h19;
      8'h51: c = 8'h29;  8'h52: c = 8'h39;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Turns one usage into at most one event.
  function automatic ev_t usage_event(input logic [7:0] u, input logic [7:0] mods,
                                      input logic down);
    ev_t        e;
    logic [7:0] c;
    e = '0;
    e.kind = EV_KEY;
    c = usage_code(u);
    if (u == 8'h00) begin
      e.valid = 1'b0;
    end else if ((u == USAGE_PAUSE || u == USAGE_SCROLL) && down) begin
      e.valid = 1'b1;
      e.kind  = EV_BREAK;
    end else if (u == USAGE_DELETE) begin
      e.valid = down;
      e.kind  = EV_CHOOSER;
    end else begin
      if ((mods & SHIFT_BITS) != 8'h00 && (u == USAGE_STAR || u == USAGE_COLON)) begin
        c = CODE_SHIFTED;
      end
      e.valid   = (c != 8'h00);
      e.row     = c[6:4];
      e.col     = c[3:0];
      e.pressed = down;
    end
    return e;
  endfunction

endpackage

/* rtl/hrkm_front.sv */
// Front end: accepts reports, drops unusable ones and unpacks key slots into a job.
`timescale 1ns / 1ps

module hrkm_front #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic [7:0]               in_report_length,
  input  logic [7:0]               in_report_byte_0,
  input  logic [7:0]               in_report_byte_1,
  input  logic [7:0]               in_report_byte_2,
  input  logic [7:0]               in_report_byte_3,
  input  logic [7:0]               in_report_byte_4,
  input  logic [7:0]               in_report_byte_5,
  input  logic [7:0]               in_report_byte_6,
  input  logic [7:0]               in_report_byte_7,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [KEY_SLOTS*8+8:0]   q_data
);
  import hrkm_pkg::*;

  logic [7:0] rb [8];
  logic [7:0] keys [KEY_SLOTS];
  logic [7:0] mods;
  logic       len7;
  logic       usable;
  logic       has_star;
  logic       shift_now;
  int         pos;

  assign rb[0] = in_report_byte_0;
  assign rb[1] = in_report_byte_1;
  assign rb[2] = in_report_byte_2;
  assign rb[3] = in_report_byte_3;
  assign rb[4] = in_report_byte_4;
  assign rb[5] = in_report_byte_5;
  assign rb[6] = in_report_byte_6;
  assign rb[7] = in_report_byte_7;

  assign len7   = (in_report_length == 8'd7);
  assign usable = in_mode || len7 || (in_report_length >= 8'd8);

  // Link close is handled as an empty report with no modifiers.
  always_comb begin
    has_star = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      pos = i + (len7 ? 1 : 2);
      if (in_mode || pos > 7) begin
        keys[i] = 8'h00;
      end else begin
        keys[i] = rb[pos[2:0]];
      end
      if (keys[i] == USAGE_STAR) begin
        has_star = 1'b1;
      end
    end
  end

  assign mods      = in_mode ? 8'h00 : in_report_byte_0;
  assign shift_now = ((mods & SHIFT_BITS) != 8'h00) && !has_star;

  always_comb begin
    q_data[0]   = shift_now;
    q_data[8:1] = mods;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      q_data[9 + i*8 +: 8] = keys[i];
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && usable;

endmodule

/* rtl/hrkm_queue.sv */
// Two-entry request queue between the front end and the event sequencer.
`timescale 1ns / 1ps

module hrkm_queue #(
  parameter int WIDTH = 57
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/hrkm_back.sv */
// Event sequencer: walks one job slot by slot, holds key state and drives the result register.
`timescale 1ns / 1ps

module hrkm_back #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_not_empty,
  input  logic [KEY_SLOTS*8+8:0]   q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_event_kind,
  output logic [2:0]               out_matrix_row,
  output logic [3:0]               out_matrix_column,
  output logic                     out_pressed,
  output logic                     out_last_event
);
  import hrkm_pkg::*;

  localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  st_t          state_r, state_nxt;
  logic [IW-1:0] idx_r;
  logic [3:0]   cnt_r;
  logic [7:0]   job_keys_r [KEY_SLOTS];
  logic [7:0]   job_mods_r;
  logic         job_shift_r;
  logic [7:0]   held_r [KEY_SLOTS];
  logic [7:0]   held_mods_r;
  ev_t          pend_r;
  logic         out_valid_r;
  ev_t          out_ev_r;
  logic         out_last_r;

  logic         scanning;
  logic         slot_last;
  logic         out_free;
  logic         step;
  logic         cand_ok;
  logic         out_load;
  logic         flush_done;
  logic         shift_was;
  logic         old_ctrl;
  logic         new_ctrl;
  logic         held_star;
  logic         in_other;
  logic [7:0]   u;
  ev_t          cand;

  assign scanning  = (state_r == ST_RELEASE) || (state_r == ST_SHIFT) ||
                     (state_r == ST_CTRL) || (state_r == ST_PRESS);
  assign slot_last = (idx_r == IW'(KEY_SLOTS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign cand_ok   = cand.valid && (cnt_r < MAX_EVENTS);
  // A new event needs the pending slot free, or the pending one must move on.
  assign step      = !cand_ok || !pend_r.valid || out_free;
  assign flush_done = (state_r == ST_FLUSH) && (!pend_r.valid || out_free);
  assign out_load  = pend_r.valid && out_free &&
                     ((scanning && cand_ok) || (state_r == ST_FLUSH));
  assign q_pop     = (state_r == ST_IDLE) && q_not_empty;

  always_comb begin
    held_star = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_r[i] == USAGE_STAR) begin
        held_star = 1'b1;
      end
    end
  end

  assign shift_was = ((held_mods_r & SHIFT_BITS) != 8'h00) && !held_star;
  assign old_ctrl  = (held_mods_r & CONTROL_BITS) != 8'h00;
  assign new_ctrl  = (job_mods_r & CONTROL_BITS) != 8'h00;

  // Releases look for the old usage among the new keys, presses the reverse.
  always_comb begin
    u = (state_r == ST_RELEASE) ? held_r[idx_r] : job_keys_r[idx_r];
    in_other = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if ((state_r == ST_RELEASE) ? (job_keys_r[i] == u) : (held_r[i] == u)) begin
        in_other = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:    state_nxt = q_not_empty ? ST_RELEASE : ST_IDLE;
      ST_RELEASE: state_nxt = (step && slot_last) ? ST_SHIFT : ST_RELEASE;
      ST_SHIFT:   state_nxt = step ? ST_CTRL : ST_SHIFT;
      ST_CTRL:    state_nxt = step ? ST_PRESS : ST_CTRL;
      ST_PRESS:   state_nxt = (step && slot_last) ? ST_FLUSH : ST_PRESS;
      ST_FLUSH:   state_nxt = flush_done ? ST_IDLE : ST_FLUSH;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cand = '0;
    cand.kind = EV_KEY;
    unique case (state_r)
      ST_RELEASE: begin
        if (u != 8'h00 && !in_other) begin
          cand = usage_event(u, held_mods_r, 1'b0);
        end
      end
      ST_SHIFT: begin
        cand.valid   = (shift_was != job_shift_r);
        cand.pressed = job_shift_r;
      end
      ST_CTRL: begin
        cand.valid   = (old_ctrl != new_ctrl);
        cand.col     = 4'd1;
        cand.pressed = new_ctrl;
      end
      ST_PRESS: begin
        if (u != 8'h00 && !in_other) begin
          cand = usage_event(u, job_mods_r, 1'b1);
        end
      end
      default: cand = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= 4'd0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      held_mods_r <= 8'h00;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_r[i] <= 8'h00;
      end
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        idx_r <= '0;
        cnt_r <= 4'd0;
      end else if ((state_r == ST_RELEASE || state_r == ST_PRESS) && step) begin
        idx_r <= slot_last ? '0 : idx_r + 1'b1;
      end
      if (scanning && step && cand_ok) begin
        cnt_r  <= cnt_r + 4'd1;
        pend_r <= cand;
      end else if (flush_done) begin
        pend_r.valid <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (flush_done) begin
        held_mods_r <= job_mods_r;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          held_r[i] <= job_keys_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_shift_r <= q_head[0];
      job_mods_r  <= q_head[8:1];
      for (int i = 0; i < KEY_SLOTS; i++) begin
        job_keys_r[i] <= q_head[9 + i*8 +: 8];
      end
    end
    if (out_load) begin
      out_ev_r   <= pend_r;
      out_last_r <= (state_r == ST_FLUSH);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_ev_r.kind;
  assign out_matrix_row    = out_ev_r.row;
  assign out_matrix_column = out_ev_r.col;
  assign out_pressed       = out_ev_r.pressed;
  assign out_last_event    = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r.valid)
    else $error("pending event left behind at end of request");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_EVENTS)
    else $error("event count beyond limit");

  a_fresh_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELEASE && $past(state_r) == ST_IDLE) |-> (cnt_r == 4'd0 && idx_r == '0))
    else $error("sequencer did not restart cleanly");

endmodule

/* rtl/hid_report_to_key_matrix.sv */
// Top level of the keyboard report to key-matrix event translator.
`timescale 1ns / 1ps

// Each accepted report is compared with the one held from before and turned into up to
// fourteen key-matrix events: releases of vanished keys, then shift and control changes,
// then presses of new keys, with last_event set on the final one. A report that yields
// nothing, or has a length below seven, gives no result. The front end pushes each report
// into a two-entry queue and can accept more while the sequencer works. The sequencer walks
// a job one slot or modifier per cycle while the result register is not stalled. A stalled
// result register holds the sequencer; the front end goes on until the queue is full.
module hid_report_to_key_matrix #(
  parameter int KEY_SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_report_length,
  input  logic [7:0] in_report_byte_0,
  input  logic [7:0] in_report_byte_1,
  input  logic [7:0] in_report_byte_2,
  input  logic [7:0] in_report_byte_3,
  input  logic [7:0] in_report_byte_4,
  input  logic [7:0] in_report_byte_5,
  input  logic [7:0] in_report_byte_6,
  input  logic [7:0] in_report_byte_7,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [2:0] out_matrix_row,
  output logic [3:0] out_matrix_column,
  output logic       out_pressed,
  output logic       out_last_event
);
  import hrkm_pkg::*;

  localparam int JW = KEY_SLOTS * 8 + 9;

  logic          q_full;
  logic          q_push;
  logic [JW-1:0] q_data;
  logic          q_pop;
  logic          q_not_empty;
  logic [JW-1:0] q_head;

  hrkm_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_report_length (in_report_length),
    .in_report_byte_0 (in_report_byte_0),
    .in_report_byte_1 (in_report_byte_1),
    .in_report_byte_2 (in_report_byte_2),
    .in_report_byte_3 (in_report_byte_3),
    .in_report_byte_4 (in_report_byte_4),
    .in_report_byte_5 (in_report_byte_5),
    .in_report_byte_6 (in_report_byte_6),
    .in_report_byte_7 (in_report_byte_7),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_data)
  );

  hrkm_queue #(.WIDTH(JW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  hrkm_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_matrix_row    (out_matrix_row),
    .out_matrix_column (out_matrix_column),
    .out_pressed       (out_pressed),
    .out_last_event    (out_last_event)
  );

endmodule

/* test/tb.sv */
// Self-checking bench for the keyboard report to key-matrix translator, with its own event predictor.
`timescale 1ns / 1ps

module tb;
  import hrkm_pkg::*;

  localparam int SLOTS        = 6;
  localparam int EVENT_CAP    = 14;
  localparam int RANDOM_ITEMS = 280;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic            mode;
    logic [7:0]      len;
    logic [7:0][7:0] b;
  } report_t;

  typedef struct {
    ev_kind_t   kind;
    logic [2:0] row;
    logic [3:0] col;
    logic       pressed;
    logic       last;
  } key_event_t;

  logic       clk;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_stall;
  logic       in_mode           = 1'b0;
  logic [7:0] in_report_length  = 8'h00;
  logic [7:0] in_report_byte_0  = 8'h00;
  logic [7:0] in_report_byte_1  = 8'h00;
  logic [7:0] in_report_byte_2  = 8'h00;
  logic [7:0] in_report_byte_3  = 8'h00;
  logic [7:0] in_report_byte_4  = 8'h00;
  logic [7:0] in_report_byte_5  = 8'h00;
  logic [7:0] in_report_byte_6  = 8'h00;
  logic [7:0] in_report_byte_7  = 8'h00;
  logic       out_valid;
  logic       out_stall         = 1'b0;
  logic [1:0] out_event_kind;
  logic [2:0] out_matrix_row;
  logic [3:0] out_matrix_column;
  logic       out_pressed;
  logic       out_last_event;

  hid_report_to_key_matrix #(.KEY_SLOTS(SLOTS)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_report_length  (in_report_length),
    .in_report_byte_0  (in_report_byte_0),
    .in_report_byte_1  (in_report_byte_1),
    .in_report_byte_2  (in_report_byte_2),
    .in_report_byte_3  (in_report_byte_3),
    .in_report_byte_4  (in_report_byte_4),
    .in_report_byte_5  (in_report_byte_5),
    .in_report_byte_6  (in_report_byte_6),
    .in_report_byte_7  (in_report_byte_7),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_matrix_row    (out_matrix_row),
    .out_matrix_column (out_matrix_column),
    .out_pressed       (out_pressed),
    .out_last_event    (out_last_event)
  );

  report_t          report_backlog[$];
  key_event_t       matrix_events[$];
  report_t          drive_item;
  logic             report_taken = 1'b0;
  int               reports_taken = 0;
  int               mismatches = 0;
  int               quiet_cycles = 0;
  int               hold_left = 0;
  bit               hold_done = 1'b0;
  int               step_events;

  // Predictor state: keys and modifiers of the previous report.
  logic [SLOTS-1:0][7:0] held_keys = '0;
  logic [7:0]            held_mods = 8'h00;

  // Generator state, so that random reports evolve like real typing.
  logic [SLOTS-1:0][7:0] gen_keys = '0;
  logic [7:0]            gen_mods = 8'h00;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Row in the high nibble, column in the low nibble; zero is unmapped.
  function automatic logic [7:0] matrix_code(input logic [7:0] u);
    logic [7:0] c;
    case (u)
      8'h04: c = 8'h41; 8'h05: c = 8'h64; 8'h06: c = 8'h52; 8'h07: c = 8'h32;
      8'h08: c = 8'h22; 8'h09: c = 8'h43; 8'h0a: c = 8'h53; 8'h0b: c = 8'h54;
      8'h0c: c = 8'h25; 8'h0d: c = 8'h45; 8'h0e: c = 8'h46; 8'h0f: c = 8'h56;
      8'h10: c = 8'h65; 8'h11: c = 8'h55; 8'h12: c = 8'h36; 8'h13: c = 8'h37;
      8'h14: c = 8'h10; 8'h15: c = 8'h33; 8'h16: c = 8'h51; 8'h17: c = 8'h23;
      8'h18: c = 8'h35; 8'h19: c = 8'h63; 8'h1a: c = 8'h21; 8'h1b: c = 8'h42;
      8'h1c: c = 8'h44; 8'h1d: c = 8'h61; 8'h1e: c = 8'h30; 8'h1f: c = 8'h31;
      8'h20: c = 8'h11; 8'h21: c = 8'h12; 8'h22: c = 8'h13; 8'h23: c = 8'h34;
      8'h24: c = 8'h24; 8'h25: c = 8'h15; 8'h26: c = 8'h26; 8'h27: c = 8'h27;
      8'h28: c = 8'h49; 8'h29: c = 8'h70; 8'h2a: c = 8'h59; 8'h2b: c = 8'h60;
      8'h2c: c = 8'h62; 8'h2d: c = 8'h57; 8'h2e: c = 8'h17; 8'h2f: c = 8'h38;
      8'h30: c = 8'h58; 8'h31: c = 8'h78; 8'h33: c = 8'h47; 8'h34: c = 8'h48;
      8'h35: c = 8'h28; 8'h36: c = 8'h66; 8'h37: c = 8'h67; 8'h38: c = 8'h68;
      8'h39: c = 8'h40; 8'h3a: c = 8'h71; 8'h3b: c = 8'h72; 8'h3c: c = 8'h73;
      8'h3d: c = 8'h14; 8'h3e: c = 8'h74; 8'h3f: c = 8'h75; 8'h40: c = 8'h16;
      8'h41: c = 8'h76; 8'h42: c = 8'h77; 8'h43: c = 8'h20; 8'h49: c = 8'h69;
      8'h4c: c = 8'h59; 8'h4f: c = 8'h79; 8'h50: c = 8'h19; 8'h51: c = 8'h29;
      8'h52: c = 8'h39;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic bit has_usage(input logic [SLOTS-1:0][7:0] list, input logic [7:0] u);
    bit found;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) if (list[i] == u) found = 1'b1;
    return found;
  endfunction

  // A held star key swallows shift.
  function automatic bit shift_down(input logic [SLOTS-1:0][7:0] list, input logic [7:0] mods);
    return ((mods & SHIFT_BITS) != 8'h00) && !has_usage(list, USAGE_STAR);
  endfunction

  task automatic add_event(input ev_kind_t kind, input logic [2:0] row, input logic [3:0] col,
                           input logic down);
    key_event_t e;
    if (step_events < EVENT_CAP) begin
      e.kind    = kind;
      e.row     = row;
      e.col     = col;
      e.pressed = down;
      e.last    = 1'b0;
      matrix_events.push_back(e);
      step_events++;
    end
  endtask

  task automatic key_change(input logic [7:0] u, input logic [7:0] mods, input logic down);
    logic [7:0] code;
    if (u == 8'h00) begin
    end else if ((u == USAGE_PAUSE || u == USAGE_SCROLL) && down) begin
      add_event(EV_BREAK, 3'd0, 4'd0, 1'b0);
    end else if (u == USAGE_DELETE) begin
      if (down) add_event(EV_CHOOSER, 3'd0, 4'd0, 1'b0);
    end else begin
      if ((mods & SHIFT_BITS) != 8'h00 && (u == USAGE_STAR || u == USAGE_COLON))
        code = CODE_SHIFTED;
      else
        code = matrix_code(u);
      if (code != 8'h00) add_event(EV_KEY, code[6:4], code[3:0], down);
    end
  endtask

  task automatic translate_report(input report_t r);
    logic [SLOTS-1:0][7:0] keys;
    logic [7:0]            mods;
    int                    base;
    bit                    shift_was, shift_now, old_ctrl, new_ctrl;
    step_events = 0;
    if (r.mode) begin
      for (int i = 0; i < SLOTS; i++) key_change(held_keys[i], held_mods, 1'b0);
      if (shift_down(held_keys, held_mods)) add_event(EV_KEY, 3'd0, 4'd0, 1'b0);
      if ((held_mods & CONTROL_BITS) != 8'h00) add_event(EV_KEY, 3'd0, 4'd1, 1'b0);
      held_keys = '0;
      held_mods = 8'h00;
    end else if (r.len >= 8'd7) begin
      mods = r.b[0];
      base = (r.len == 8'd7) ? 1 : 2;
      for (int i = 0; i < SLOTS; i++) keys[i] = (base + i <= 7) ? r.b[base + i] : 8'h00;
      shift_was = shift_down(held_keys, held_mods);
      shift_now = shift_down(keys, mods);
      old_ctrl  = (held_mods & CONTROL_BITS) != 8'h00;
      new_ctrl  = (mods & CONTROL_BITS) != 8'h00;
      for (int i = 0; i < SLOTS; i++)
        if (held_keys[i] != 8'h00 && !has_usage(keys, held_keys[i]))
          key_change(held_keys[i], held_mods, 1'b0);
      if (shift_was != shift_now) add_event(EV_KEY, 3'd0, 4'd0, shift_now);
      if (old_ctrl != new_ctrl) add_event(EV_KEY, 3'd0, 4'd1, new_ctrl);
      for (int i = 0; i < SLOTS; i++)
        if (keys[i] != 8'h00 && !has_usage(held_keys, keys[i]))
          key_change(keys[i], mods, 1'b1);
      held_keys = keys;
      held_mods = mods;
    end
    if (step_events > 0) matrix_events[matrix_events.size() - 1].last = 1'b1;
  endtask

  task automatic send(input logic m, input logic [7:0] len, input logic [63:0] bytes);
    report_t r;
    r.mode = m;
    r.len  = len;
    r.b    = bytes;
    report_backlog.push_back(r);
  endtask

  // Boot form: keys are given as {k5, ..., k0}; the reserved byte is random.
  task automatic send_boot(input logic [7:0] mods, input logic [47:0] keys);
    send(1'b0, 8'd8, {keys, 8'($urandom), mods});
  endtask

  function automatic logic [7:0] pick_usage();
    logic [7:0] u;
    int         r;
    r = $urandom_range(99);
    if (r < 20) u = 8'h00;
    else if (r < 32) begin
      case ($urandom_range(4))
        0: u = USAGE_PAUSE;
        1: u = USAGE_SCROLL;
        2: u = USAGE_DELETE;
        3: u = USAGE_STAR;
        default: u = USAGE_COLON;
      endcase
    end else if (r < 90) u = 8'($urandom_range(8'h04, 8'h53));
    else u = 8'($urandom);
    return u;
  endfunction

  function automatic logic [7:0] pick_mods();
    logic [7:0] m;
    case ($urandom_range(7))
      0: m = 8'h00;
      1: m = 8'h02;
      2: m = 8'h20;
      3: m = 8'h01;
      4: m = 8'h10;
      5: m = 8'h33;
      default: m = 8'($urandom);
    endcase
    return m;
  endfunction

  task automatic queue_random_report();
    report_t r;
    int      sel;
    sel    = $urandom_range(99);
    r.mode = 1'b0;
    r.len  = 8'd8;
    r.b    = {$urandom, $urandom};
    if (sel < 6) begin
      r.mode   = 1'b1;
      r.len    = 8'($urandom);
      gen_keys = '0;
      gen_mods = 8'h00;
    end else if (sel < 12) begin
      // Noise: any length, any content, including the ignored short lengths.
      r.len = 8'($urandom);
    end else begin
      repeat ($urandom_range(3)) gen_keys[$urandom_range(SLOTS - 1)] = pick_usage();
      if ($urandom_range(1)) gen_mods = pick_mods();
      r.b[0] = gen_mods;
      if (sel < 22) begin
        r.len = 8'd7;
        for (int i = 0; i < SLOTS; i++) r.b[i + 1] = gen_keys[i];
      end else begin
        r.len = (sel < 30) ? 8'($urandom_range(9, 255)) : 8'd8;
        for (int i = 0; i < SLOTS; i++) r.b[i + 2] = gen_keys[i];
      end
    end
    report_backlog.push_back(r);
  endtask

  function automatic bit quiet_phase();
    return reports_taken >= 40 && reports_taken < 100;
  endfunction

  // Request driver: a new request is put up only once the previous one has gone.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || report_taken)) begin
      if (report_backlog.size() != 0 && (quiet_phase() || $urandom_range(99) >= 26)) begin
        drive_item        = report_backlog.pop_front();
        in_mode          <= drive_item.mode;
        in_report_length <= drive_item.len;
        in_report_byte_0 <= drive_item.b[0];
        in_report_byte_1 <= drive_item.b[1];
        in_report_byte_2 <= drive_item.b[2];
        in_report_byte_3 <= drive_item.b[3];
        in_report_byte_4 <= drive_item.b[4];
        in_report_byte_5 <= drive_item.b[5];
        in_report_byte_6 <= drive_item.b[6];
        in_report_byte_7 <= drive_item.b[7];
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to fill the block, and a quiet stretch.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && reports_taken >= 120) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet_phase() && ($urandom_range(99) < 26);
    end
  end

  // Monitor, predictor and watchdog.
  always @(posedge clk) begin
    key_event_t e;
    report_t    r;
    report_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (matrix_events.size() == 0) begin
          $display("%0t: event expected none actual kind=%0d row=%0d col=%0d pressed=%0d last=%0d",
                   $time, out_event_kind, out_matrix_row, out_matrix_column, out_pressed,
                   out_last_event);
          mismatches++;
        end else begin
          e = matrix_events.pop_front();
          if (out_event_kind != e.kind) begin
            $display("%0t: event_kind expected %0d actual %0d", $time, e.kind, out_event_kind);
            mismatches++;
          end
          if (out_matrix_row != e.row) begin
            $display("%0t: matrix_row expected %0d actual %0d", $time, e.row, out_matrix_row);
            mismatches++;
          end
          if (out_matrix_column != e.col) begin
            $display("%0t: matrix_column expected %0d actual %0d", $time, e.col,
                     out_matrix_column);
            mismatches++;
          end
          if (out_pressed != e.pressed) begin
            $display("%0t: pressed expected %0d actual %0d", $time, e.pressed, out_pressed);
            mismatches++;
          end
          if (out_last_event != e.last) begin
            $display("%0t: last_event expected %0d actual %0d", $time, e.last, out_last_event);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        r.mode = in_mode;
        r.len  = in_report_length;
        r.b    = {in_report_byte_7, in_report_byte_6, in_report_byte_5, in_report_byte_4,
                  in_report_byte_3, in_report_byte_2, in_report_byte_1, in_report_byte_0};
        translate_report(r);
        reports_taken++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    // Key press, then star with shift, which swallows the shift key itself.
    send_boot(8'h00, 48'h00_00_00_00_00_04);
    send_boot(8'h02, 48'h00_00_00_00_25_04);
    // Star goes up shifted, shift comes back, colon goes down shifted.
    send_boot(8'h20, 48'h00_00_00_00_33_04);
    send_boot(8'h11, 48'h00_00_00_00_33_04);
    send(1'b1, 8'h5a, 64'h0123_4567_89ab_cdef);
    send(1'b1, 8'h00, 64'h0);
    // Break, break, chooser; their releases give nothing.
    send_boot(8'h00, 48'h00_00_00_4c_48_45);
    send_boot(8'h00, 48'h00_00_00_00_00_00);
    // Short form: keys from byte 1, byte 7 is not looked at.
    send(1'b0, 8'd7, 64'h29_2c_28_1e_1f_20_21_00);
    send(1'b0, 8'd6, 64'hffff_ffff_ffff_ffff);
    send(1'b0, 8'd0, 64'h0000_0004_0004_0022);
    // Longest length, all modifiers, duplicate and unmapped usages.
    send(1'b0, 8'd255, 64'h00_05_ff_32_04_04_ff_ff);
    // Six keys swapped for six others together with both modifiers: fourteen events.
    send_boot(8'h00, 48'h0b_0a_09_08_07_06);
    send_boot(8'h33, 48'h11_10_0f_0e_0d_0c);
    send(1'b0, 8'd8, 64'hffff_ffff_ffff_ffff);
    send(1'b0, 8'd8, 64'h0);
    send(1'b1, 8'hff, 64'hffff_ffff_ffff_ffff);
    send_boot(8'h01, 48'h00_00_00_00_00_25);
    send_boot(8'h02, 48'h00_00_00_00_00_25);
    send_boot(8'h02, 48'h00_00_00_00_00_33);
    send(1'b1, 8'd8, 64'h0);
    repeat (RANDOM_ITEMS) queue_random_report();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (report_backlog.size() != 0 || in_valid) @(posedge clk);
    while (matrix_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && matrix_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
